// ===== src/tsc_pkg.sv =====
// shared types, constants and crc function for the scratchpad checker
package tsc_pkg;

    localparam logic [7:0]  CRC_SHIFT_CONST = 8'h8C;
    localparam logic [7:0]  RESERVED_VALUE  = 8'h10;
    localparam logic [3:0]  FRAME_LAST_IDX  = 4'd8;
    localparam logic [3:0]  TEMP_LOW_IDX    = 4'd0;
    localparam logic [3:0]  TEMP_HIGH_IDX   = 4'd1;
    localparam logic [3:0]  RESERVED_IDX    = 4'd7;
    localparam logic signed [15:0] TEMP_LOW_LIMIT  = -16'sd880;
    localparam logic signed [15:0] TEMP_HIGH_LIMIT = 16'sd2000;

    localparam logic [15:0] MASK_9BIT  = 16'hFFF8;
    localparam logic [15:0] MASK_10BIT = 16'hFFFC;
    localparam logic [15:0] MASK_11BIT = 16'hFFFE;

    localparam logic [1:0]  RESOLUTION_RESET = 2'd3;

    typedef enum logic [1:0] {
        RES_9BIT  = 2'd0,
        RES_10BIT = 2'd1,
        RES_11BIT = 2'd2,
        RES_12BIT = 2'd3
    } resolution_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CRC_ERR  = 2'd1,
        STATUS_RSVD_ERR = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic        done;
        logic [7:0]  crc;
        logic [15:0] raw;
        logic        reserved_ok;
    } frame_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_SHIFT_CONST;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== src/tsc_frame.sv =====
// frame tracker: byte count, running crc, temperature bytes and reserved check
module tsc_frame
    import tsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output frame_t     frame
);

    logic [7:0] crc_reg, crc_next;
    logic [3:0] count_reg, count_next;
    logic       rsvd_reg, rsvd_next;
    logic [7:0] lo_reg;
    logic [7:0] hi_reg;
    logic [3:0] idx;
    logic [7:0] crc_base;
    logic [7:0] crc_new;
    logic       last;

    always_comb
    begin
        idx      = frame_start ? TEMP_LOW_IDX : count_reg;
        crc_base = (idx == TEMP_LOW_IDX) ? 8'd0 : crc_reg;
        crc_new  = crc8_update(crc_base, data_byte);
        last     = (idx == FRAME_LAST_IDX);

        crc_next   = crc_reg;
        count_next = count_reg;
        rsvd_next  = rsvd_reg;
        if (accept)
        begin
            if (last)
            begin
                crc_next   = 8'd0;
                count_next = 4'd0;
                rsvd_next  = 1'b0;
            end
            else
            begin
                crc_next   = crc_new;
                count_next = idx + 4'd1;
                if (idx == TEMP_LOW_IDX)
                    rsvd_next = 1'b0;
                else if (idx == RESERVED_IDX)
                    rsvd_next = (data_byte == RESERVED_VALUE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 8'd0;
            count_reg <= 4'd0;
            rsvd_reg  <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            rsvd_reg  <= rsvd_next;
        end
    end

    // temperature bytes
    always_ff @(posedge clk)
    begin
        if (accept && idx == TEMP_LOW_IDX)
            lo_reg <= data_byte;
        if (accept && idx == TEMP_HIGH_IDX)
            hi_reg <= data_byte;
    end

    assign frame.done        = accept && last;
    assign frame.crc         = crc_new;
    assign frame.raw         = {hi_reg, lo_reg};
    assign frame.reserved_ok = rsvd_reg;

endmodule

// ===== src/tsc_result.sv =====
// result evaluation: resolution mask, status priority and output register
module tsc_result
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      frame,
    input  resolution_t resolution,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [15:0] temperature,
    output logic [1:0]  status
);

    logic        valid_reg, valid_next;
    logic [15:0] temp_reg;
    status_t     status_reg;
    logic [15:0] masked;
    logic signed [15:0] value;
    status_t     stat;
    logic [15:0] temp_out;

    always_comb
    begin
        case (resolution)
            RES_9BIT:  masked = frame.raw & MASK_9BIT;
            RES_10BIT: masked = frame.raw & MASK_10BIT;
            RES_11BIT: masked = frame.raw & MASK_11BIT;
            default:   masked = frame.raw;
        endcase
        value = $signed(masked);

        if (frame.crc != 8'd0)
            stat = STATUS_CRC_ERR;
        else if (!frame.reserved_ok)
            stat = STATUS_RSVD_ERR;
        else if (!(value > TEMP_LOW_LIMIT && value < TEMP_HIGH_LIMIT))
            stat = STATUS_RANGE;
        else
            stat = STATUS_OK;

        // no meaningful temperature on crc or reserved errors
        temp_out = (stat == STATUS_CRC_ERR || stat == STATUS_RSVD_ERR) ? 16'd0 : masked;

        if (frame.done)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            temp_reg   <= temp_out;
            status_reg <= stat;
        end
    end

    assign out_valid   = valid_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

endmodule

// ===== src/temp_scratchpad_checker_top.sv =====
// top level of the temperature scratchpad checker
// the result of a frame is registered into the output register when byte 8 is accepted
// throughput: one byte per cycle; a request is taken whenever the output register
// is empty or being drained in the same cycle
// reset: crc, byte count, reserved check and output valid clear; resolution resets to 12 bit
module temp_scratchpad_checker_top
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] temperature,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    resolution_t resolution_reg;
    frame_t      frame;
    logic        accept;
    logic [15:0] temp_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            resolution_reg <= resolution_t'(RESOLUTION_RESET);
        else if (cfg_we)
            resolution_reg <= resolution_t'(cfg_wdata);
    end

    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    tsc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .frame       (frame)
    );

    tsc_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .resolution  (resolution_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .temperature (temp_bits),
        .status      (status)
    );

    assign temperature = $signed(temp_bits);

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the temperature scratchpad checker: directed and random frames, scoreboard check
`timescale 1ns / 1ps

module tb;
    import tsc_pkg::*;

    localparam int FRAME_LEN = 9;

    typedef struct {
        logic signed [15:0] temperature;
        status_t            status;
    } reading_t;

    class reading_scoreboard;
        reading_t    expected_readings [$];
        resolution_t resolution;
        logic [7:0]  crc;
        int          byte_index;
        logic [7:0]  low_byte;
        logic [7:0]  high_byte;
        bit          reserved_seen;
        int          mismatches;

        function new();
            resolution    = resolution_t'(RESOLUTION_RESET);
            crc           = 8'h00;
            byte_index    = 0;
            low_byte      = 8'h00;
            high_byte     = 8'h00;
            reserved_seen = 1'b0;
            mismatches    = 0;
        endfunction

        function logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
            logic [7:0] c;
            c = crc_in ^ data;
            repeat (8)
                c = {1'b0, c[7:1]} ^ (c[0] ? CRC_SHIFT_CONST : 8'h00);
            return c;
        endfunction

        function void set_resolution(input resolution_t r);
            resolution = r;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void take_byte(input logic [7:0] data, input bit mark);
            logic signed [15:0] raw;
            reading_t           want;
            if (mark || byte_index >= FRAME_LEN)
                byte_index = 0;
            if (byte_index == 0)
            begin
                crc           = 8'h00;
                reserved_seen = 1'b0;
            end
            crc = crc_byte(crc, data);
            if (byte_index == int'(TEMP_LOW_IDX))
                low_byte = data;
            else if (byte_index == int'(TEMP_HIGH_IDX))
                high_byte = data;
            else if (byte_index == int'(RESERVED_IDX))
                reserved_seen = (data == RESERVED_VALUE);
            byte_index++;
            if (byte_index < FRAME_LEN)
                return;
            raw = {high_byte, low_byte};
            case (resolution)
                RES_9BIT:  raw = raw & MASK_9BIT;
                RES_10BIT: raw = raw & MASK_10BIT;
                RES_11BIT: raw = raw & MASK_11BIT;
                default:   ;
            endcase
            if (crc != 8'h00)
                want.status = STATUS_CRC_ERR;
            else if (!reserved_seen)
                want.status = STATUS_RSVD_ERR;
            else if (!(raw > TEMP_LOW_LIMIT && raw < TEMP_HIGH_LIMIT))
                want.status = STATUS_RANGE;
            else
                want.status = STATUS_OK;
            want.temperature = (want.status == STATUS_CRC_ERR || want.status == STATUS_RSVD_ERR)
                               ? 16'sd0 : raw;
            expected_readings.push_back(want);
            byte_index    = 0;
            crc           = 8'h00;
            reserved_seen = 1'b0;
        endfunction

        function void log_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_reading(input logic signed [15:0] temp, input logic [1:0] stat);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                log_mismatch($sformatf("unexpected reading: temperature %0d status %0d",
                                       temp, stat));
                return;
            end
            want = expected_readings.pop_front();
            if (temp !== want.temperature)
                log_mismatch($sformatf("temperature mismatch: expected %0d got %0d",
                                       want.temperature, temp));
            if (stat !== want.status)
                log_mismatch($sformatf("status mismatch: expected %0d got %0d",
                                       want.status, stat));
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte   = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic signed [15:0] temperature;
    logic [1:0]         status;
    logic               cfg_we      = 1'b0;
    logic [1:0]         cfg_wdata   = 2'd0;

    reading_scoreboard board;
    int                in_idle_pct    = 0;
    int                out_stall_pct  = 0;
    int                requests_sent  = 0;

    temp_scratchpad_checker_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temperature (temperature),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_reading(temperature, status);
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_byte(input logic [7:0] data, input bit mark);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid    <= 1'b1;
        data_byte   <= data;
        frame_start <= mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_byte(data, mark);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [15:0] raw, input logic [7:0] rsvd,
                              input int bad_idx, input int length, input bit mark);
        logic [7:0] frame [FRAME_LEN];
        logic [7:0] crc;
        crc      = 8'h00;
        frame[0] = raw[7:0];
        frame[1] = raw[15:8];
        for (int i = 2; i < 7; i++)
            frame[i] = 8'($urandom_range(255));
        frame[7] = rsvd;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            crc = board.crc_byte(crc, frame[i]);
        frame[8] = crc;
        if (bad_idx >= 0)
            frame[bad_idx] = frame[bad_idx] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < length; i++)
            send_byte(frame[i], (i == 0) && mark);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_resolution(input resolution_t r);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_resolution(r);
    endtask

    function automatic logic [15:0] pick_temp();
        logic signed [15:0] edges [14];
        int                 r;
        int                 v;
        edges = '{-16'sd881, -16'sd880, -16'sd879, -16'sd873, -16'sd872, 16'sd0, -16'sd1,
                  16'sd1, 16'sd1999, 16'sd2000, 16'sd2001, 16'sd2007, 16'sh7FFF, 16'sh8000};
        r = $urandom_range(99);
        v = $urandom_range(2880);
        if (r < 40)
            return edges[$urandom_range(13)];
        if (r < 70)
            return 16'(v - 880);
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic run_traffic(input int quota);
        int target;
        int kind;
        int n;
        target = requests_sent + quota;
        while (requests_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                send_frame(pick_temp(), RESERVED_VALUE, -1, FRAME_LEN, $urandom_range(9) != 0);
            else if (kind < 80)
                send_frame(pick_temp(), 8'($urandom_range(255)), -1, FRAME_LEN, 1'b1);
            else if (kind < 88)
                send_frame(pick_temp(), RESERVED_VALUE, $urandom_range(FRAME_LEN - 1),
                           FRAME_LEN, 1'b1);
            else if (kind < 94)
                send_frame(pick_temp(), RESERVED_VALUE, -1, $urandom_range(1, FRAME_LEN - 1),
                           1'b1);
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
            if ($urandom_range(49) == 0)
                drain();
        end
        send_frame(pick_temp(), RESERVED_VALUE, -1, FRAME_LEN, 1'b1);
    endtask

    initial
    begin
        int idle_plan [4];
        int stall_plan [4];
        idle_plan  = '{0, 65, 0, 38};
        stall_plan = '{0, 0, 65, 38};
        board = new();
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // partial frame cut short by a new frame start
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_frame(16'h0191, RESERVED_VALUE, -1, FRAME_LEN, 1'b1);
        // no frame start after a finished frame, lower range edge
        send_frame(16'hFC90, RESERVED_VALUE, -1, FRAME_LEN, 1'b0);
        // crc error wins over a bad reserved byte
        send_frame(16'h7FFF, 8'h00, FRAME_LEN - 1, FRAME_LEN, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            if (p >= 1 && p <= 4)
                write_resolution(resolution_t'(p - 1));
            else if (p > 4)
                write_resolution(resolution_t'($urandom_range(3)));
            in_idle_pct   = idle_plan[p % 4];
            out_stall_pct = stall_plan[p % 4];
            run_traffic(185);
        end

        drain();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
